@@ hdl/htlf_pkg.sv @@
// Shared types and constants for the handle table allocator.
// Holds the request mode codes, controller states and the control/status structs.
// No dependencies; the top level, htlf_ctrl and htlf_dp import this package.
package htlf_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int MODE_W        = 2;
    localparam int INDEX_W       = 8;
    localparam int VALUE_W       = 64;
    localparam int GROUP_W       = 16;

    // Request kinds carried on the input tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the request and start the slot read
        logic execute;  // apply the request and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } stat_t;

endpackage

@@ hdl/handle_table_lowest_free_alloc_top.sv @@
// Handle table with lowest-free-slot allocation, top level.
// Each request is handled in two steps, accept and then execute, one item at a time.
// A new request is taken only after the previous one has executed; the slot RAM read is registered.
// Reset (rst_n, asynchronous, active low) empties the occupancy bitmap; no RAM sweep is needed.
// Depends on htlf_pkg, htlf_ctrl, htlf_dp and htlf_ram.
module handle_table_lowest_free_alloc_top
    import htlf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [7:0] slot_index, [71:8] entry_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] given_handle, [71:8] read_value,
                                   // [72] table_empty, [79:73] zero
    output logic [0:0]  m_tuser    // [0] status
);

    // The controller takes one request per transfer and, from the execute
    // state, tells the datapath to apply it once the result register is free.
    // The datapath keeps the occupancy bitmap in flip-flops, so a slot whose
    // bit is clear reads as zero and the value RAM never has to be cleared:
    // both reset and the clear request just zero the bitmap.
    //
    // The slot RAM read for release and lookup is launched at the input
    // transfer, so its data is ready in the execute cycle. Allocation picks
    // the lowest free slot with a grouped priority encoder over the bitmap
    // and writes the value in the execute cycle.
    //
    // The result register decouples the two sides: a new request is taken
    // while a finished result still waits for the downstream side.

    cmd_t               cmd;
    stat_t              stat;
    logic [INDEX_W-1:0] out_handle;
    logic [VALUE_W-1:0] out_value;
    logic               out_status;
    logic               out_empty;

    htlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htlf_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (s_tuser),
        .in_index   (s_tdata[7:0]),
        .in_value   (s_tdata[71:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_handle (out_handle),
        .out_value  (out_value),
        .out_status (out_status),
        .out_empty  (out_empty)
    );

    assign m_tdata = {7'd0, out_empty, out_value, out_handle};
    assign m_tuser = out_status;

endmodule

@@ hdl/htlf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the slot value store.
module htlf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/htlf_ctrl.sv @@
// Controller state machine for the handle table allocator.
// Depends on htlf_pkg for the state enum and the command/status structs.
module htlf_ctrl
    import htlf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Finish only when the result has somewhere to go.
                if (stat.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/htlf_dp.sv @@
// Datapath of the handle table allocator: request registers, occupancy bitmap,
// lowest-free-slot encoder, slot value RAM and the result register.
// Depends on htlf_pkg and htlf_ram.
module htlf_dp
    import htlf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [INDEX_W-1:0] in_index,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [INDEX_W-1:0] out_handle,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_status,
    output logic               out_empty
);

    localparam int AW      = $clog2(SLOTS);
    localparam int NGROUPS = (SLOTS + GROUP_W - 1) / GROUP_W;
    localparam int GIW     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int GBW     = $clog2(GROUP_W);
    localparam int PAD     = NGROUPS * GROUP_W;
    localparam logic [INDEX_W:0] SLOT_LIMIT = (INDEX_W+1)'(SLOTS);

    mode_t              req_mode_reg;
    logic [INDEX_W-1:0] req_index_reg;
    logic [VALUE_W-1:0] req_value_reg;
    logic [SLOTS-1:0]   occ_reg;
    logic [SLOTS-1:0]   occ_next;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_handle_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_status_reg;
    logic               out_empty_reg;

    logic [PAD-1:0]     free_pad;
    logic [NGROUPS-1:0] group_any;
    logic [GIW-1:0]     grp_sel;
    logic [GROUP_W-1:0] grp_bits;
    logic [GBW-1:0]     bit_sel;
    logic               free_found;
    logic [GIW+GBW-1:0] free_full;
    logic [AW-1:0]      free_idx;

    logic [AW-1:0]      req_addr;
    logic               in_range;
    logic [VALUE_W-1:0] ram_rdata;
    logic               ram_we;
    logic [INDEX_W-1:0] res_handle;
    logic [VALUE_W-1:0] res_value;
    logic               res_status;

    assign stat.out_free = !out_valid_reg || out_ready;

    // Request registers, loaded when the controller accepts an item.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_mode_reg  <= mode_t'(in_mode);
            req_index_reg <= in_index;
            req_value_reg <= in_value;
        end
    end

    // Lowest free slot: groups of GROUP_W bits, first free group, then first bit.
    always_comb
    begin
        for (int i = 0; i < PAD; i++)
        begin
            free_pad[i] = (i < SLOTS) ? !occ_reg[i] : 1'b0;
        end
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_any[g] = |free_pad[g*GROUP_W +: GROUP_W];
        end
        grp_sel = '0;
        for (int g = NGROUPS - 1; g >= 0; g--)
        begin
            if (group_any[g])
            begin
                grp_sel = GIW'(g);
            end
        end
        grp_bits = free_pad[grp_sel*GROUP_W +: GROUP_W];
        bit_sel  = '0;
        for (int b = GROUP_W - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                bit_sel = GBW'(b);
            end
        end
        free_found = |group_any;
        free_full  = {grp_sel, bit_sel};
        free_idx   = free_full[AW-1:0];
    end

    assign req_addr = req_index_reg[AW-1:0];
    assign in_range = {1'b0, req_index_reg} < SLOT_LIMIT;

    // Apply the request to the bitmap and form the result.
    always_comb
    begin
        occ_next   = occ_reg;
        res_handle = '0;
        res_value  = '0;
        res_status = 1'b0;
        ram_we     = 1'b0;
        case (req_mode_reg)
            MODE_ALLOC:
            begin
                if (req_value_reg != '0 && free_found)
                begin
                    occ_next[free_idx] = 1'b1;
                    res_handle         = INDEX_W'(free_idx);
                    ram_we             = 1'b1;
                end
                else
                begin
                    res_status = 1'b1;
                end
            end
            MODE_RELEASE, MODE_LOOKUP:
            begin
                if (in_range)
                begin
                    // An empty slot reads as zero whatever the RAM still holds.
                    res_value = occ_reg[req_addr] ? ram_rdata : '0;
                    if (req_mode_reg == MODE_RELEASE)
                    begin
                        occ_next[req_addr] = 1'b0;
                    end
                end
                else
                begin
                    res_status = 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                occ_next = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            out_handle_reg <= res_handle;
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_empty_reg  <= (occ_next == '0);
        end
    end

    htlf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.execute && ram_we),
        .waddr (free_idx),
        .wdata (req_value_reg),
        .re    (cmd.accept),
        .raddr (in_index[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_handle = out_handle_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_empty  = out_empty_reg;

endmodule
